[src/dsam_pkg.sv]
// Shared types, constants and zone tables of the disk sector allocation map.
package dsam_pkg;

   localparam int CMD_W          = 2;
   localparam int TRACK_W        = 6;
   localparam int SECTOR_W       = 5;
   localparam int OFFSET_W       = 18;
   localparam int COUNT_W        = 5;
   localparam int STATUS_W       = 2;
   localparam int MAP_W          = 21;
   localparam int START_W        = 10;
   localparam int ZONES          = 4;
   localparam int MAX_TRACKS_DEF = 42;
   localparam int SECTOR_BYTES   = 256;
   localparam int SECTOR_SHIFT   = $clog2(SECTOR_BYTES);

   localparam logic [TRACK_W-1:0] MIN_TRACKS   = TRACK_W'(35);
   localparam logic [TRACK_W-1:0] FIRST_SEARCH = TRACK_W'(17);
   localparam logic [TRACK_W-1:0] LAST_SEARCH  = TRACK_W'(18);

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND   = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_FREE   = 2'd2,
      CMD_FORMAT = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_SAME = 2'd1,
      ST_NONE = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [MAP_W-1:0]   map;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [TRACK_W-1:0]  wr_track;
      entry_type           wr_entry;
      logic [TRACK_W-1:0]  rd_track;
      logic                clear;
      logic [TRACK_W-1:0]  clear_tc;
   } store_ctl_type;

   typedef struct packed {
      logic [TRACK_W-1:0]  result_track;
      logic [SECTOR_W-1:0] result_sector;
      logic [OFFSET_W-1:0] byte_offset;
      logic [COUNT_W-1:0]  track_free_count;
      logic [STATUS_W-1:0] status;
   } res_type;

   typedef struct packed {
      logic                hit;
      logic [SECTOR_W-1:0] sector;
   } find_type;

   localparam logic [COUNT_W-1:0] ZONE_SECTORS [ZONES] = '{5'd21, 5'd19, 5'd18, 5'd17};

   localparam logic [MAP_W-1:0] ZONE_FULL [ZONES] = '{
      21'h1FFFFF, 21'h07FFFF, 21'h03FFFF, 21'h01FFFF
   };

   // sector visited at each interleave step, per zone
   localparam logic [SECTOR_W-1:0] SEQ [ZONES][MAP_W] = '{
      '{5'd0, 5'd10, 5'd20, 5'd9, 5'd19, 5'd8, 5'd18, 5'd7, 5'd17, 5'd6, 5'd16,
        5'd5, 5'd15, 5'd4, 5'd14, 5'd3, 5'd13, 5'd2, 5'd12, 5'd1, 5'd11},
      '{5'd0, 5'd10, 5'd1, 5'd11, 5'd2, 5'd12, 5'd3, 5'd13, 5'd4, 5'd14, 5'd5,
        5'd15, 5'd6, 5'd16, 5'd7, 5'd17, 5'd8, 5'd18, 5'd9, 5'd0, 5'd10},
      '{5'd0, 5'd10, 5'd2, 5'd12, 5'd4, 5'd14, 5'd6, 5'd16, 5'd8, 5'd0, 5'd10,
        5'd2, 5'd12, 5'd4, 5'd14, 5'd6, 5'd16, 5'd8, 5'd0, 5'd10, 5'd2},
      '{5'd0, 5'd10, 5'd3, 5'd13, 5'd6, 5'd16, 5'd9, 5'd2, 5'd12, 5'd5, 5'd15,
        5'd8, 5'd1, 5'd11, 5'd4, 5'd14, 5'd7, 5'd0, 5'd10, 5'd3, 5'd13}
   };

   function automatic logic [1:0] zone_of(input logic [TRACK_W-1:0] t);
      if (t <= TRACK_W'(17)) return 2'd0;
      if (t <= TRACK_W'(24)) return 2'd1;
      if (t <= TRACK_W'(30)) return 2'd2;
      return 2'd3;
   endfunction

   function automatic logic [COUNT_W-1:0] sectors_of(input logic [TRACK_W-1:0] t);
      return ZONE_SECTORS[zone_of(t)];
   endfunction

   function automatic logic [START_W-1:0] track_start(input logic [TRACK_W-1:0] t);
      logic [START_W-1:0] tw;
      tw = START_W'(t);
      case (zone_of(t))
         2'd0:    return START_W'((tw - START_W'(1)) * START_W'(21));
         2'd1:    return START_W'(START_W'(357) + (tw - START_W'(18)) * START_W'(19));
         2'd2:    return START_W'(START_W'(490) + (tw - START_W'(25)) * START_W'(18));
         default: return START_W'(START_W'(598) + (tw - START_W'(31)) * START_W'(17));
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] offset_of(input logic [TRACK_W-1:0] t,
                                                     input logic [SECTOR_W-1:0] s);
      logic [START_W-1:0] sum;
      sum = START_W'(track_start(t) + START_W'(s));
      return OFFSET_W'(OFFSET_W'(sum) << SECTOR_SHIFT);
   endfunction

   // first free sector in interleave order
   function automatic find_type first_free(input logic [MAP_W-1:0] map,
                                           input logic [1:0] zone);
      find_type f;
      f = '0;
      for (int j = MAP_W - 1; j >= 0; j--) begin
         if (map[SEQ[zone][j]]) begin
            f.hit    = 1'b1;
            f.sector = SEQ[zone][j];
         end
      end
      return f;
   endfunction

endpackage

[src/dsam_if.sv]
// Handshake channel interfaces of the disk sector allocation map.
interface dsam_req_if import dsam_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [TRACK_W-1:0]  track;
   logic [SECTOR_W-1:0] sector;
   modport source (output valid, command, track, sector, input ready);
   modport sink (input valid, command, track, sector, output ready);
endinterface

interface dsam_rsp_if import dsam_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TRACK_W-1:0]  result_track;
   logic [SECTOR_W-1:0] result_sector;
   logic [OFFSET_W-1:0] byte_offset;
   logic [COUNT_W-1:0]  track_free_count;
   logic [STATUS_W-1:0] status;
   modport source (output valid, result_track, result_sector, byte_offset,
                   track_free_count, status, input ready);
   modport sink (input valid, result_track, result_sector, byte_offset,
                 track_free_count, status, output ready);
endinterface

interface dsam_csr_if import dsam_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TRACK_W-1:0] track_count;
   modport source (output valid, track_count, input ready);
   modport sink (input valid, track_count, output ready);
endinterface

[src/disk_sector_allocation_map.sv]
// Top level of the disk sector allocation map: command sequencer and result register.
// Usage:
//   req_chan takes one command transaction (command, track, sector) when valid and
//   ready are high; ready is high only while the sequencer is idle.
//   rsp_chan returns exactly one result transaction per command from an output
//   register; a stalled receiver holds the result, and a finished command waits in
//   its last state until the register frees, so nothing is lost.
//   csr_chan writes track_count (saturated to 35..MAX_TRACKS) and is always ready;
//   write it only while no command is in flight.
// Find reads one track entry per cycle from the single memory read port, in the
//   order 17 down to 1 then track_count down to 18, and picks the first free
//   sector of a track in interleave order in the cycle its entry arrives.
// Commands run one at a time; the next is taken the cycle after the result
//   is loaded.
// Reset: track_count returns to 35 and every track up to track_count reads as
//   freshly formatted at once (per-track valid bits, no clearing pass); format works the same way.
module disk_sector_allocation_map import dsam_pkg::*; #(
   parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
   input logic      clock,
   input logic      reset,
   dsam_req_if.sink   req_chan,
   dsam_rsp_if.source rsp_chan,
   dsam_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_READ,
      S_EXEC,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [TRACK_W-1:0]  trk_ff, trk_in;
   logic [SECTOR_W-1:0] sec_ff, sec_in;
   logic [TRACK_W-1:0]  tc_ff, tc_in;
   logic [TRACK_W-1:0]  iss_trk_ff, iss_trk_in;
   logic                iss_done_ff, iss_done_in;
   logic                pend_ff, pend_in;
   logic                pend_last_ff, pend_last_in;
   logic [TRACK_W-1:0]  eval_trk_ff, eval_trk_in;
   res_type             res_ff, res_in;
   res_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   store_ctl_type       ctl;
   entry_type           ent;
   find_type            fnd;
   logic [MAP_W-1:0]    mask;
   logic                bit_set;
   logic                bad;
   logic [TRACK_W-1:0]  csr_tc;

   dsam_store #(
      .MAX_TRACKS (MAX_TRACKS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rd_entry (ent)
   );

   assign fnd     = first_free(ent.map, zone_of(eval_trk_ff));
   assign mask    = MAP_W'(1) << sec_ff;
   assign bit_set = |(ent.map & mask);
   assign bad     = (trk_ff == '0) || (trk_ff > tc_ff) ||
                    (COUNT_W'(sec_ff) >= sectors_of(trk_ff));

   always_comb begin
      if (csr_chan.track_count < MIN_TRACKS) begin
         csr_tc = MIN_TRACKS;
      end else if (csr_chan.track_count > TRACK_W'(MAX_TRACKS)) begin
         csr_tc = TRACK_W'(MAX_TRACKS);
      end else begin
         csr_tc = csr_chan.track_count;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      trk_in       = trk_ff;
      sec_in       = sec_ff;
      tc_in        = tc_ff;
      iss_trk_in   = iss_trk_ff;
      iss_done_in  = iss_done_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      eval_trk_in  = eval_trk_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      ctl.clear_tc = tc_ff;
      ctl.wr_track = trk_ff;

      if (csr_chan.valid) begin
         tc_in = csr_tc;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in = cmd_type'(req_chan.command);
               trk_in = req_chan.track;
               sec_in = req_chan.sector;
               unique case (cmd_type'(req_chan.command))
                  CMD_FIND: begin
                     iss_trk_in  = FIRST_SEARCH;
                     iss_done_in = 1'b0;
                     pend_in     = 1'b0;
                     state_in    = S_FIND;
                  end
                  CMD_FORMAT: begin
                     ctl.clear     = 1'b1;
                     res_in        = '0;
                     res_in.status = ST_OK;
                     state_in      = S_DONE;
                  end
                  default: begin
                     state_in = S_READ;
                  end
               endcase
            end
         end
         S_FIND: begin
            ctl.rd_track = iss_trk_ff;
            pend_in      = !iss_done_ff;
            pend_last_in = (iss_trk_ff == LAST_SEARCH);
            eval_trk_in  = iss_trk_ff;
            iss_trk_in   = (iss_trk_ff == TRACK_W'(1)) ? tc_ff : iss_trk_ff - TRACK_W'(1);
            iss_done_in  = iss_done_ff || (iss_trk_ff == LAST_SEARCH);
            if (pend_ff && (ent.count != '0) && fnd.hit) begin
               res_in.result_track     = eval_trk_ff;
               res_in.result_sector    = fnd.sector;
               res_in.byte_offset      = offset_of(eval_trk_ff, fnd.sector);
               res_in.track_free_count = ent.count;
               res_in.status           = ST_OK;
               state_in                = S_DONE;
            end else if (pend_ff && pend_last_ff) begin
               res_in        = '0;
               res_in.status = ST_NONE;
               state_in      = S_DONE;
            end
         end
         S_READ: begin
            ctl.rd_track = trk_ff;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            res_in.result_track     = trk_ff;
            res_in.result_sector    = sec_ff;
            res_in.byte_offset      = offset_of(trk_ff, sec_ff);
            res_in.track_free_count = ent.count;
            if (bad) begin
               res_in.byte_offset      = '0;
               res_in.track_free_count = '0;
               res_in.status           = ST_BAD;
            end else if (cmd_ff == CMD_ALLOC) begin
               if (ent.count == '0) begin
                  res_in.status = ST_NONE;
               end else if (!bit_set) begin
                  res_in.status = ST_SAME;
               end else begin
                  ctl.wr_en               = 1'b1;
                  ctl.wr_entry.map        = ent.map & ~mask;
                  ctl.wr_entry.count      = ent.count - COUNT_W'(1);
                  res_in.track_free_count = ent.count - COUNT_W'(1);
                  res_in.status           = ST_OK;
               end
            end else begin
               if (bit_set) begin
                  res_in.status = ST_SAME;
               end else begin
                  ctl.wr_en               = 1'b1;
                  ctl.wr_entry.map        = ent.map | mask;
                  ctl.wr_entry.count      = ent.count + COUNT_W'(1);
                  res_in.track_free_count = ent.count + COUNT_W'(1);
                  res_in.status           = ST_OK;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      trk_ff       <= trk_in;
      sec_ff       <= sec_in;
      iss_trk_ff   <= iss_trk_in;
      iss_done_ff  <= iss_done_in;
      pend_last_ff <= pend_last_in;
      eval_trk_ff  <= eval_trk_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tc_ff        <= MIN_TRACKS;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tc_ff        <= tc_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign csr_chan.ready            = 1'b1;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_track     = rsp_ff.result_track;
   assign rsp_chan.result_sector    = rsp_ff.result_sector;
   assign rsp_chan.byte_offset      = rsp_ff.byte_offset;
   assign rsp_chan.track_free_count = rsp_ff.track_free_count;
   assign rsp_chan.status           = rsp_ff.status;

   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> (state_ff == S_EXEC) && !bad)
      else $error("map write outside allocate/free execution");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_chan.ready |=> (state_ff == S_DONE))
      else $error("result left done state while output register busy");

   a_hit_in_track: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_OK) && (rsp_chan.result_track != '0)
      |-> (COUNT_W'(rsp_chan.result_sector) < sectors_of(rsp_chan.result_track)))
      else $error("reported sector outside its track");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.track_free_count <= COUNT_W'(MAP_W)))
      else $error("free count above sectors per track");

endmodule

[src/dsam_store.sv]
// Per-track free bitmap and free count memory with format-default valid bits.
module dsam_store import dsam_pkg::*; #(
   parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  store_ctl_type ctl,
   output entry_type     rd_entry
);

   localparam int ADDR_W = $clog2(MAX_TRACKS);

   entry_type             mem [MAX_TRACKS];
   logic [MAX_TRACKS-1:0] valid_ff, valid_in;
   logic [TRACK_W-1:0]    fmt_tc_ff, fmt_tc_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [TRACK_W-1:0]    rd_track_ff;
   entry_type             rd_data_ff;
   logic [TRACK_W-1:0]    rd_t1, wr_t1;
   logic                  rd_ok;
   logic [ADDR_W-1:0]     rd_addr, wr_addr;
   logic [1:0]            zone;
   logic                  formatted;

   assign rd_t1   = ctl.rd_track - TRACK_W'(1);
   assign wr_t1   = ctl.wr_track - TRACK_W'(1);
   assign rd_ok   = (ctl.rd_track != '0) && (ctl.rd_track <= TRACK_W'(MAX_TRACKS));
   assign rd_addr = rd_ok ? rd_t1[ADDR_W-1:0] : '0;
   assign wr_addr = wr_t1[ADDR_W-1:0];

   always_comb begin
      valid_in    = valid_ff;
      fmt_tc_in   = fmt_tc_ff;
      rd_valid_in = rd_ok && valid_ff[rd_addr];
      if (ctl.clear) begin
         valid_in  = '0;
         fmt_tc_in = ctl.clear_tc;
      end else if (ctl.wr_en) begin
         valid_in = valid_ff | (MAX_TRACKS'(1) << wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_entry;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_track_ff <= ctl.rd_track;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fmt_tc_ff   <= MIN_TRACKS;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         fmt_tc_ff   <= fmt_tc_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign zone      = zone_of(rd_track_ff);
   assign formatted = (rd_track_ff != '0) && (rd_track_ff <= fmt_tc_ff);

   always_comb begin
      if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else if (formatted) begin
         rd_entry.map   = ZONE_FULL[zone];
         rd_entry.count = ZONE_SECTORS[zone];
      end else begin
         rd_entry = '0;
      end
   end

endmodule
